>>> hdl/sbgp_pkg.sv
// ============================================================================
// sbgp_pkg: shared types and constants for the six-button gamepad port
// Holds the operation codes, the decoded queue entry and the queue sizing.
// ============================================================================
`default_nettype none

package sbgp_pkg;

  // Operation codes as they arrive on the input channel.
  localparam logic [1:0] OP_DIR_WR  = 2'd0;
  localparam logic [1:0] OP_DATA_WR = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;
  localparam logic [1:0] OP_TICK    = 2'd3;

  // Decoded operation kind carried through the queue.
  typedef enum logic [1:0] {
    KIND_DIR_WR,
    KIND_DATA_WR,
    KIND_READ,
    KIND_TICK
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [7:0]  value;
    logic [11:0] buttons;
  } q_entry_t;

  // Queue between front and back.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Scanline limit reset value and select bit position.
  localparam logic [7:0] LIMIT_RESET = 8'd25;
  localparam int         SELECT_BIT  = 6;

  // Queue status seen by the front.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage : sbgp_pkg

`default_nettype wire

>>> hdl/six_button_gamepad_port_top.sv
// ============================================================================
// six_button_gamepad_port_top: six-button gamepad port
// Direction, data, read and scanline operations on a multiplexed pad port.
// ============================================================================
//
//   Channel  Direction  Handshake           Payload
//   in_      input      in_valid/in_stall   in_op, in_value, in_buttons
//   out_     output     out_valid/out_stall out_read_data
//   cfg_     input      cfg_wr_en           cfg_wr_data (scanline limit)
//
// The back end retires one queue entry per clock unless a read is held by a
// stalled output, so the block sustains one input beat per clock while no
// read is held. An accepted read beat is written into the queue and then
// popped into the output register by the single execute step of the back end.
// Reset is synchronous and active low; it clears the queue, resets the port
// state, clears the output valid flag and loads the scanline limit with 25.
// An output stall holds a read at the head of the queue, and the entries
// behind it wait with it; the four-entry queue absorbs input while it waits.
//
`default_nettype none

module six_button_gamepad_port_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_op,
  input  wire logic [7:0]  in_value,
  input  wire logic [11:0] in_buttons,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_read_data
);
  import sbgp_pkg::*;

  // Front to queue.
  q_status_t q_status;
  logic      push;
  q_entry_t  push_entry;

  // Queue to back.
  logic      pop;
  logic      pop_valid;
  q_entry_t  pop_entry;

  // The front decodes the opcode and stalls the input only when the queue
  // is full, so input acceptance never waits on the output side directly.
  sbgp_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_value   (in_value),
    .in_buttons (in_buttons),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  // The queue lets the front keep accepting beats while a read result is
  // held by a stalled output.
  sbgp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .q_status   (q_status),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry)
  );

  // The back end owns all port state: direction register, data latch,
  // select line, phase and scanline counters, and the scanline limit.
  // Entries execute strictly in order, so every read sees exactly the
  // state left by the operations before it.
  sbgp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .pop_valid     (pop_valid),
    .pop_entry     (pop_entry),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data)
  );

endmodule : six_button_gamepad_port_top

`default_nettype wire

>>> hdl/sbgp_front.sv
// ============================================================================
// sbgp_front: input acceptance and operation decode
// Accepts input beats while the queue has room and decodes each into an entry.
// ============================================================================
`default_nettype none

module sbgp_front (
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_op,
  input  wire logic [7:0]        in_value,
  input  wire logic [11:0]       in_buttons,
  input  wire sbgp_pkg::q_status_t q_status,
  output logic                   push,
  output sbgp_pkg::q_entry_t     push_entry
);
  import sbgp_pkg::*;

  op_kind_t kind;

  always_comb begin
    unique case (in_op)
      OP_DIR_WR:  kind = KIND_DIR_WR;
      OP_DATA_WR: kind = KIND_DATA_WR;
      OP_READ:    kind = KIND_READ;
      OP_TICK:    kind = KIND_TICK;
      default:    kind = KIND_TICK;
    endcase
  end

  // The stall comes from the registered fill count, never from in_valid.
  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  assign push_entry.kind    = kind;
  assign push_entry.value   = in_value;
  assign push_entry.buttons = in_buttons;

endmodule : sbgp_front

`default_nettype wire

>>> hdl/sbgp_queue.sv
// ============================================================================
// sbgp_queue: short decoupling queue
// Register-based FIFO of decoded entries between the front and the back.
// ============================================================================
`default_nettype none

module sbgp_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire sbgp_pkg::q_entry_t push_entry,
  output sbgp_pkg::q_status_t     q_status,
  input  wire logic               pop,
  output logic                    pop_valid,
  output sbgp_pkg::q_entry_t      pop_entry
);
  import sbgp_pkg::*;

  q_entry_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic                 do_pop;

  assign do_pop = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  assign q_status.full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign q_status.empty = (count_r == '0);
  assign pop_valid      = (count_r != '0);
  assign pop_entry      = mem_r[rd_ptr_r];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH))
    else $error("queue fill count exceeds depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == Q_CNT_W'(Q_DEPTH)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with fill count");

  a_push_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue push without pop did not raise the fill count");

endmodule : sbgp_queue

`default_nettype wire

>>> hdl/sbgp_back.sv
// ============================================================================
// sbgp_back: port state and read formatting
// Runs queued ops one a cycle unless output stalls a read; holds read results.
// ============================================================================
`default_nettype none

module sbgp_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [7:0]         cfg_wr_data,
  input  wire logic               pop_valid,
  input  wire sbgp_pkg::q_entry_t pop_entry,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_read_data
);
  import sbgp_pkg::*;

  logic [7:0] limit_r;
  logic [7:0] dir_r, dir_nxt;
  logic [7:0] data_r, data_nxt;
  logic       sel_r, sel_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [7:0] line_r, line_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r, out_data_nxt;
  logic       out_free;
  logic       is_read;
  logic [8:0] line_inc;
  logic [7:0] raw;

  // Pad byte for the current phase and select level, before the merge.
  function automatic logic [7:0] pad_byte(input logic sel, input logic [1:0] phase,
                                          input logic [11:0] b);
    logic [7:0] r;
    if (sel) begin
      if (phase == 2'd3) r = {2'b01, b[5:4], b[11:8]};
      else               r = {2'b01, b[5:0]};
    end else begin
      r = {2'b00, b[7:6], 4'b0000};
      if (phase != 2'd2) r[1:0] = b[1:0];
      if (phase == 2'd3) r[3:0] = 4'hF;
    end
    return r;
  endfunction

  assign is_read  = (pop_entry.kind == KIND_READ);
  assign out_free = !out_valid_r || !out_stall;
  assign pop      = pop_valid && (!is_read || out_free);
  assign line_inc = {1'b0, line_r} + 9'd1;
  assign raw      = pad_byte(sel_r, phase_r, pop_entry.buttons);

  always_comb begin
    dir_nxt       = dir_r;
    data_nxt      = data_r;
    sel_nxt       = sel_r;
    phase_nxt     = phase_r;
    line_nxt      = line_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (pop) begin
      case (pop_entry.kind) inside
        KIND_DIR_WR, KIND_DATA_WR: begin
          if (pop_entry.kind == KIND_DIR_WR) dir_nxt  = pop_entry.value;
          else                               data_nxt = pop_entry.value;
          // Select follows the data bit only while that pin is an output.
          sel_nxt = dir_nxt[SELECT_BIT] ? data_nxt[SELECT_BIT] : 1'b1;
          if (!sel_r && sel_nxt) begin
            phase_nxt = phase_r + 2'd1;
            line_nxt  = '0;
          end
        end
        KIND_READ: begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = (raw & ~dir_r) | (data_r & dir_r);
        end
        default: begin
          if (line_inc > {1'b0, limit_r}) begin
            phase_nxt = '0;
            line_nxt  = '0;
          end else begin
            line_nxt = line_inc[7:0];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RESET;
      dir_r       <= '0;
      data_r      <= '0;
      sel_r       <= 1'b1;
      phase_r     <= '0;
      line_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) limit_r <= cfg_wr_data;
      dir_r       <= dir_nxt;
      data_r      <= data_nxt;
      sel_r       <= sel_nxt;
      phase_r     <= phase_nxt;
      line_r      <= line_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

  a_read_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && is_read) |=> out_valid_r)
    else $error("popped read did not reach the output register");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && is_read) |-> out_free)
    else $error("read popped over an undelivered result");

  a_sel_rise: assert property (@(posedge clk) disable iff (!rst_n)
    (!sel_r && sel_nxt) |=> (line_r == '0 && phase_r == $past(phase_r) + 2'd1))
    else $error("select rising edge did not advance phase and clear line count");

endmodule : sbgp_back

`default_nettype wire
